>>> rtl/tgvi_pkg.sv
// Shared types and constants of the triangle grid vector interpolator.
package tgvi_pkg;

  localparam int NODE_COUNT  = 262144;
  localparam int ADDR_W      = $clog2(NODE_COUNT);
  localparam int VEL_W       = 32;
  localparam int POS_W       = 25;
  localparam int GRID_W      = 10;
  localparam int SCALE_W     = 24;
  localparam int FRAC_W      = 16;
  localparam int WGT_W       = FRAC_W + 1;
  localparam int PROD_W      = POS_W + SCALE_W;
  localparam int CELL_W      = PROD_W - 2 * FRAC_W;
  localparam int ROW_W       = CELL_W + GRID_W;
  localparam int TOP_W       = ROW_W + 1;
  localparam int CMDQ_DEPTH  = 2;
  localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);
  localparam int CFG_ADDR_W  = 4;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_HEIGHT = 2'd1,
    REG_CELL_SCALE  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic                    operation;
    logic [17:0]             node_index;
    logic signed [VEL_W-1:0] node_u;
    logic signed [VEL_W-1:0] node_v;
    logic [POS_W-1:0]        pos_x;
    logic [POS_W-1:0]        pos_y;
  } in_word_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] vel_u;
    logic signed [VEL_W-1:0] vel_v;
    logic                    outside;
  } out_word_t;

  typedef struct packed {
    logic [GRID_W-1:0]  grid_width;
    logic [GRID_W-1:0]  grid_height;
    logic [SCALE_W-1:0] cell_scale;
  } cfg_t;

  typedef struct packed {
    logic                    is_write;
    logic                    outside;
    logic [ADDR_W-1:0]       addr0;
    logic [ADDR_W-1:0]       addr1;
    logic [ADDR_W-1:0]       addr2;
    logic [WGT_W-1:0]        w0;
    logic [WGT_W-1:0]        w1;
    logic [WGT_W-1:0]        w2;
    logic signed [VEL_W-1:0] data_u;
    logic signed [VEL_W-1:0] data_v;
  } cmd_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_MUL,
    FE_ADDR,
    FE_PUSH
  } fe_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_WAIT
  } bk_state_t;

endpackage

>>> rtl/tgvi_front.sv
// Front end: accepts words, maps positions to cells, triangles and weights.
module tgvi_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  tgvi_pkg::in_word_t in_word,
  input  tgvi_pkg::cfg_t    cfg,
  output logic              push,
  output tgvi_pkg::cmd_t    push_cmd,
  input  logic              q_full
);
  import tgvi_pkg::*;

  fe_state_t           state_r, state_nxt;
  in_word_t            word_r;
  logic [PROD_W-1:0]   prod_x_r, prod_y_r;
  logic [CELL_W-1:0]   i_r, j_r;
  logic [FRAC_W-1:0]   fx_r, fy_r;
  logic [ROW_W-1:0]    jw_r;

  logic                accept;
  logic [CELL_W:0]     i1, j1;
  logic [TOP_W-1:0]    row1, top, a0;
  logic                oob, lower;

  assign busy   = (state_r != FE_IDLE);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FE_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word_r <= in_word;
    end
    if (state_r == FE_MUL) begin
      prod_x_r <= PROD_W'(word_r.pos_x) * PROD_W'(cfg.cell_scale);
      prod_y_r <= PROD_W'(word_r.pos_y) * PROD_W'(cfg.cell_scale);
    end
    if (state_r == FE_ADDR) begin
      i_r  <= prod_x_r[PROD_W-1 -: CELL_W];
      j_r  <= prod_y_r[PROD_W-1 -: CELL_W];
      fx_r <= prod_x_r[2*FRAC_W-1 -: FRAC_W];
      fy_r <= prod_y_r[2*FRAC_W-1 -: FRAC_W];
      jw_r <= ROW_W'(prod_y_r[PROD_W-1 -: CELL_W]) * ROW_W'(cfg.grid_width);
    end
  end

  // Corner addresses and bounds.
  always_comb begin
    i1    = {1'b0, i_r} + (CELL_W+1)'(1);
    j1    = {1'b0, j_r} + (CELL_W+1)'(1);
    row1  = TOP_W'(jw_r) + TOP_W'(cfg.grid_width);
    top   = row1 + TOP_W'(i1);
    a0    = TOP_W'(jw_r) + TOP_W'(i_r);
    lower = (fx_r >= fy_r);
    oob   = (i1 >= (CELL_W+1)'(cfg.grid_width)) ||
            (j1 >= (CELL_W+1)'(cfg.grid_height)) ||
            (top >= TOP_W'(NODE_COUNT));

    push_cmd          = '0;
    push_cmd.data_u   = word_r.node_u;
    push_cmd.data_v   = word_r.node_v;
    if (word_r.operation == OP_WRITE) begin
      push_cmd.is_write = 1'b1;
      push_cmd.addr0    = ADDR_W'(word_r.node_index);
    end else begin
      push_cmd.outside = oob;
      push_cmd.addr0   = a0[ADDR_W-1:0];
      push_cmd.addr2   = top[ADDR_W-1:0];
      if (lower) begin
        push_cmd.addr1 = a0[ADDR_W-1:0] + ADDR_W'(1);
        push_cmd.w0    = {1'b1, {FRAC_W{1'b0}}} - WGT_W'(fx_r);
        push_cmd.w1    = WGT_W'(fx_r - fy_r);
        push_cmd.w2    = WGT_W'(fy_r);
      end else begin
        push_cmd.addr1 = row1[ADDR_W-1:0] + ADDR_W'(i_r);
        push_cmd.w0    = {1'b1, {FRAC_W{1'b0}}} - WGT_W'(fy_r);
        push_cmd.w1    = WGT_W'(fy_r - fx_r);
        push_cmd.w2    = WGT_W'(fx_r);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    push      = 1'b0;
    unique case (state_r)
      FE_IDLE: begin
        if (accept) begin
          state_nxt = (in_word.operation == OP_SAMPLE) ? FE_MUL : FE_PUSH;
        end
      end
      FE_MUL:  state_nxt = FE_ADDR;
      FE_ADDR: state_nxt = FE_PUSH;
      FE_PUSH: begin
        if (!q_full) begin
          push      = 1'b1;
          state_nxt = FE_IDLE;
        end
      end
      default: state_nxt = FE_IDLE;
    endcase
  end

endmodule

>>> rtl/tgvi_cmd_queue.sv
// Short command queue between the front end and the back end.
module tgvi_cmd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tgvi_pkg::cmd_t push_cmd,
  input  logic           pop,
  output tgvi_pkg::cmd_t head,
  output logic           empty,
  output logic           full
);
  import tgvi_pkg::*;

  cmd_t                  q_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CMDQ_CNT_W-1:0] cnt_r;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign head  = q_r[rd_ptr_r];

  function automatic logic [CMDQ_PTR_W-1:0] wrap_inc(input logic [CMDQ_PTR_W-1:0] p);
    if (p == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) begin
      return '0;
    end
    return p + CMDQ_PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wrap_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= wrap_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CMDQ_CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CMDQ_CNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/tgvi_back.sv
// Back end: node memories, three-corner weighted blend, rounding and result word.
module tgvi_back (
  input  logic                clk,
  input  logic                rst_n,
  input  tgvi_pkg::cmd_t      head,
  input  logic                q_empty,
  output logic                pop,
  output tgvi_pkg::out_word_t out_word,
  output logic                out_strobe
);
  import tgvi_pkg::*;

  localparam int ACC_W = VEL_W + WGT_W;
  localparam int Q_W   = ACC_W - FRAC_W;
  localparam logic [1:0] FIRST_CORNER = 2'd0;
  localparam logic [1:0] MID_CORNER   = 2'd1;
  localparam logic [1:0] LAST_CORNER  = 2'd2;

  logic [VEL_W-1:0] mem_u [NODE_COUNT];
  logic [VEL_W-1:0] mem_v [NODE_COUNT];

  bk_state_t               state_r, state_nxt;
  logic [1:0]              cnt_r, cnt_nxt;
  cmd_t                    cmd_r;
  logic                    rd_vld_r, mul_vld_r, mul_first_r, mul_last_r, sum_rdy_r;
  logic [1:0]              rd_idx_r;
  logic signed [VEL_W-1:0] rd_u_r, rd_v_r;
  logic signed [ACC_W-1:0] prod_u_r, prod_v_r, acc_u_r, acc_v_r;
  out_word_t               out_word_r;
  logic                    out_strobe_r;

  logic                    rd_en, wr_en, out_zero;
  logic [ADDR_W-1:0]       rd_addr;
  logic [WGT_W-1:0]        wsel;
  logic signed [ACC_W:0]   prod_u_full, prod_v_full;

  assign out_word   = out_word_r;
  assign out_strobe = out_strobe_r;

  // Add half an LSB, floor to Q16.16, clamp to 32 bits.
  function automatic logic [VEL_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] rnd;
    logic [Q_W-1:0]          q;
    rnd = acc + ACC_W'(1 << (FRAC_W - 1));
    q   = rnd[ACC_W-1:FRAC_W];
    if (q[Q_W-1:VEL_W-1] == '0 || q[Q_W-1:VEL_W-1] == '1) begin
      return q[VEL_W-1:0];
    end
    return q[Q_W-1] ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
  endfunction

  always_comb begin
    case (cnt_r)
      FIRST_CORNER: rd_addr = cmd_r.addr0;
      MID_CORNER:   rd_addr = cmd_r.addr1;
      default:      rd_addr = cmd_r.addr2;
    endcase
    case (rd_idx_r)
      FIRST_CORNER: wsel = cmd_r.w0;
      MID_CORNER:   wsel = cmd_r.w1;
      default:      wsel = cmd_r.w2;
    endcase
    prod_u_full = $signed({1'b0, wsel}) * rd_u_r;
    prod_v_full = $signed({1'b0, wsel}) * rd_v_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_u[head.addr0] <= head.data_u;
      mem_v[head.addr0] <= head.data_v;
    end
    if (rd_en) begin
      rd_u_r <= mem_u[rd_addr];
      rd_v_r <= mem_v[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r <= head;
    end
    rd_idx_r <= cnt_r;
    if (rd_vld_r) begin
      prod_u_r    <= prod_u_full[ACC_W-1:0];
      prod_v_r    <= prod_v_full[ACC_W-1:0];
      mul_first_r <= (rd_idx_r == FIRST_CORNER);
      mul_last_r  <= (rd_idx_r == LAST_CORNER);
    end
    if (mul_vld_r) begin
      acc_u_r <= (mul_first_r ? '0 : acc_u_r) + prod_u_r;
      acc_v_r <= (mul_first_r ? '0 : acc_v_r) + prod_v_r;
    end
    if (sum_rdy_r) begin
      out_word_r.vel_u   <= round_sat(acc_u_r);
      out_word_r.vel_v   <= round_sat(acc_v_r);
      out_word_r.outside <= 1'b0;
    end else if (out_zero) begin
      out_word_r.vel_u   <= '0;
      out_word_r.vel_v   <= '0;
      out_word_r.outside <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_IDLE;
      cnt_r        <= '0;
      rd_vld_r     <= 1'b0;
      mul_vld_r    <= 1'b0;
      sum_rdy_r    <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      rd_vld_r     <= rd_en;
      mul_vld_r    <= rd_vld_r;
      sum_rdy_r    <= mul_vld_r && mul_last_r;
      out_strobe_r <= sum_rdy_r || out_zero;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pop       = 1'b0;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    out_zero  = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          if (head.is_write) begin
            wr_en = 1'b1;
          end else if (head.outside) begin
            out_zero = 1'b1;
          end else begin
            state_nxt = BK_READ;
            cnt_nxt   = FIRST_CORNER;
          end
        end
      end
      BK_READ: begin
        rd_en   = 1'b1;
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == LAST_CORNER) begin
          state_nxt = BK_WAIT;
        end
      end
      BK_WAIT: begin
        if (sum_rdy_r) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

endmodule

>>> rtl/triangle_grid_vector_interpolator_core.sv
// Top level of the triangle grid vector interpolator: register port and block wiring.

// Samples a 2D velocity field held on a regular node grid. A word with
// operation 0 stores node_u/node_v at node_index and gives no result; a word
// with operation 1 scales pos_x/pos_y by cell_scale, picks the lower triangle
// of the cell when fx >= fy (else the upper one), blends the three corner nodes
// with barycentric weights and returns one result word with vel_u/vel_v
// rounded and saturated to Q16.16, or outside = 1 and zero velocities when the
// cell does not lie inside the grid. Raise start with a word; it is taken on a
// clock edge where busy is low. Results appear for exactly one cycle with
// out_strobe high and cannot be stalled, so the receiver must take every one.
// After an accepted sample the front end holds busy through its multiply,
// index and queue push states, and after a write through the queue push
// state alone; the push waits while the two-entry queue is full, and no new
// word is taken until it is done. The back end owns the node memories with
// one read port: a write or an outside sample is handled as it is popped, an
// inside sample goes through three corner reads, multiply, accumulate and
// round, and the back end pops no further command until its sum is ready.
// Node memories are not cleared: reading a node never written gives an
// undefined value. Write configuration only while no sample is in flight.
module triangle_grid_vector_interpolator_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // command side
  input  logic                                start,
  output logic                                busy,
  input  tgvi_pkg::in_word_t                  in_word,
  // result side
  output logic                                out_strobe,
  output tgvi_pkg::out_word_t                 out_word,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tgvi_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import tgvi_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t reg_idx;
  logic     reg_wr;

  logic     push, pop, q_full, q_empty;
  cmd_t     push_cmd, head;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign reg_wr  = psel && penable && pwrite;

  // Registers reset to a 512 x 512 grid with unit cell size.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_width  <= GRID_W'(512);
      cfg_r.grid_height <= GRID_W'(512);
      cfg_r.cell_scale  <= SCALE_W'(65536);
    end else if (reg_wr) begin
      unique case (reg_idx)
        REG_GRID_WIDTH:  cfg_r.grid_width  <= pwdata[GRID_W-1:0];
        REG_GRID_HEIGHT: cfg_r.grid_height <= pwdata[GRID_W-1:0];
        REG_CELL_SCALE:  cfg_r.cell_scale  <= pwdata[SCALE_W-1:0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_GRID_WIDTH:  prdata = 32'(cfg_r.grid_width);
      REG_GRID_HEIGHT: prdata = 32'(cfg_r.grid_height);
      REG_CELL_SCALE:  prdata = 32'(cfg_r.cell_scale);
      default:         prdata = '0;
    endcase
  end

  // Front end: classify the word, compute cell, triangle, addresses and weights.
  tgvi_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .cfg      (cfg_r),
    .push     (push),
    .push_cmd (push_cmd),
    .q_full   (q_full)
  );

  // Keep node writes and samples in arrival order between the two halves.
  tgvi_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // Back end: node memories and the weighted blend.
  tgvi_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_empty    (q_empty),
    .pop        (pop),
    .out_word   (out_word),
    .out_strobe (out_strobe)
  );

endmodule
